/* hw/rtl/lpgc_pkg.sv */
package lpgc_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int COUNT_WIDTH     = 32;

    typedef enum logic [1:0] {
        STATUS_COUNTED  = 2'd0,
        STATUS_INSERTED = 2'd1,
        STATUS_FULL     = 2'd2,
        STATUS_REJECTED = 2'd3
    } status_t;

endpackage

/* hw/rtl/linear_probe_group_count.sv */
// Results: a key found, inserted or met with a full table gives its result strobe once its probe
// chain ends; a rejected key gives it straight from the idle state, with no probe. busy stays high while probing.
// The slot memory has a single read port, which serves one probe per cycle, so a new key is
// taken only once the last one is done. A full table costs as many probes as its size in use.
// Reset: a clearing pass writes every slot empty, with busy high; the result strobe cannot be
// stalled, the receiver must take each result in its cycle.
module linear_probe_group_count #(
    parameter int TABLE_DEPTH = lpgc_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = lpgc_pkg::KEY_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [$clog2(TABLE_DEPTH):0]      cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic [KEY_WIDTH-1:0]              key,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    home_slot,
    input  logic                              final_key,
    output logic                              result_valid,
    output logic [$clog2(TABLE_DEPTH)-1:0]    slot,
    output logic [lpgc_pkg::COUNT_WIDTH-1:0]  new_count,
    output lpgc_pkg::status_t                 status,
    output logic                              batch_done
);
    import lpgc_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = AW + 1;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_PROBE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [SW-1:0]          table_size_reg, table_size_next;
    logic                   result_valid_reg, result_valid_next;

    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [AW-1:0]          home_reg, home_next;
    logic                   final_reg, final_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [SW-1:0]          n_reg, n_next;
    logic [SW-1:0]          size_reg, size_next;
    logic [AW-1:0]          slot_reg, slot_next;
    logic [COUNT_WIDTH-1:0] new_count_reg, new_count_next;
    status_t                status_reg, status_next;
    logic                   batch_done_reg, batch_done_next;

    logic [KEY_WIDTH-1:0]   key_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]   rd_key_reg;
    logic [COUNT_WIDTH-1:0] rd_cnt_reg;

    logic                   mem_we;
    logic [AW-1:0]          wr_addr;
    logic [KEY_WIDTH-1:0]   wr_key;
    logic [COUNT_WIDTH-1:0] wr_cnt;
    logic [AW-1:0]          rd_addr;

    logic [SW-1:0]          size_eff;
    logic                   reject;
    logic                   hit;
    logic                   empty;
    logic [SW-1:0]          pos_inc;
    logic [AW-1:0]          pos_adv;
    logic [SW-1:0]          n_inc;
    logic [COUNT_WIDTH-1:0] cnt_plus;

    assign size_eff = (table_size_reg > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : table_size_reg;
    assign reject   = (key == '0) || ({1'b0, home_slot} >= size_eff);
    assign hit      = (rd_key_reg == key_reg);
    assign empty    = (rd_key_reg == '0);
    assign pos_inc  = {1'b0, pos_reg} + SW'(1);
    assign pos_adv  = (pos_inc == size_reg) ? '0 : pos_inc[AW-1:0];
    assign n_inc    = n_reg + SW'(1);
    assign cnt_plus = (rd_cnt_reg == '1) ? rd_cnt_reg : rd_cnt_reg + COUNT_WIDTH'(1);

    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign slot         = slot_reg;
    assign new_count    = new_count_reg;
    assign status       = status_reg;
    assign batch_done   = batch_done_reg;

    // The next probe address is issued in the same cycle that the current slot is checked,
    // so a chain is walked at one slot per cycle.
    always_comb
    begin
        rd_addr = home_slot;
        if (state_reg == ST_PROBE)
        begin
            rd_addr = pos_adv;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        table_size_next   = table_size_reg;
        result_valid_next = 1'b0;
        key_next          = key_reg;
        home_next         = home_reg;
        final_next        = final_reg;
        pos_next          = pos_reg;
        n_next            = n_reg;
        size_next         = size_reg;
        slot_next         = slot_reg;
        new_count_next    = new_count_reg;
        status_next       = status_reg;
        batch_done_next   = batch_done_reg;
        mem_we            = 1'b0;
        wr_addr           = pos_reg;
        wr_key            = key_reg;
        wr_cnt            = cnt_plus;

        if (cfg_valid && cfg_ready)
        begin
            table_size_next = cfg_data;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_key        = '0;
                wr_cnt        = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    final_next = final_key;
                    if (reject)
                    begin
                        result_valid_next = 1'b1;
                        slot_next         = '0;
                        new_count_next    = '0;
                        status_next       = STATUS_REJECTED;
                        batch_done_next   = final_key;
                    end
                    else
                    begin
                        key_next   = key;
                        home_next  = home_slot;
                        pos_next   = home_slot;
                        n_next     = '0;
                        size_next  = size_eff;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                batch_done_next = final_reg;
                if (hit || empty)
                begin
                    mem_we            = 1'b1;
                    wr_cnt            = hit ? cnt_plus : COUNT_WIDTH'(1);
                    result_valid_next = 1'b1;
                    slot_next         = pos_reg;
                    new_count_next    = wr_cnt;
                    status_next       = hit ? STATUS_COUNTED : STATUS_INSERTED;
                    state_next        = ST_IDLE;
                end
                else if (n_inc == size_reg)
                begin
                    // Every slot in use has been visited without a match or a hole.
                    result_valid_next = 1'b1;
                    slot_next         = home_reg;
                    new_count_next    = '0;
                    status_next       = STATUS_FULL;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    pos_next = pos_adv;
                    n_next   = n_inc;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            table_size_reg   <= SW'(TABLE_DEPTH);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            table_size_reg   <= table_size_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        home_reg       <= home_next;
        final_reg      <= final_next;
        pos_reg        <= pos_next;
        n_reg          <= n_next;
        size_reg       <= size_next;
        slot_reg       <= slot_next;
        new_count_reg  <= new_count_next;
        status_reg     <= status_next;
        batch_done_reg <= batch_done_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[wr_addr] <= wr_key;
            cnt_mem[wr_addr] <= wr_cnt;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_cnt_reg <= cnt_mem[rd_addr];
    end

    a_reject_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && key == '0) |=> (result_valid && status == STATUS_REJECTED))
        else $error("zero key was not rejected on the following cycle");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (n_reg < size_reg && {1'b0, pos_reg} < size_reg))
        else $error("probe ran beyond the table size in use");

    a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && mem_we) |=> (result_valid && state_reg == ST_IDLE))
        else $error("slot update without a result transaction");

    a_insert_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == STATUS_INSERTED) |-> (new_count == COUNT_WIDTH'(1)))
        else $error("inserted key does not report a count of one");

endmodule
